// File: rtl/core/kvi_pkg.sv
// Shared types and constants of the keyframe vector interpolator.
package kvi_pkg;

	localparam int KC_W    = 7;
	localparam int SLOT_W  = 6;
	localparam int SEG_W   = 6;
	localparam int VAL_W   = 32;
	localparam int BLEND_W = 17;
	localparam int FRAC_W  = 16;

	localparam logic [BLEND_W-1:0] BLEND_ONE  = BLEND_W'(65536);
	localparam logic [BLEND_W-1:0] BLEND_ZERO = '0;

	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	typedef struct packed {
		logic [VAL_W-1:0] time_v;
		logic [VAL_W-1:0] x;
		logic [VAL_W-1:0] y;
		logic [VAL_W-1:0] z;
	} key_t;

	typedef struct packed {
		logic             valid;
		logic             found;
		logic [SEG_W-1:0] seg;
		logic [VAL_W-1:0] t;
		key_t             pv;
		key_t             en;
	} pkt_t;

	typedef struct packed {
		logic             we;
		logic [SLOT_W-1:0] slot;
		key_t             key;
	} load_t;

endpackage

// File: rtl/core/keyframe_vector_interpolator_core.sv
// Top level of the keyframe vector interpolator: key cells, divider and blend unit.
//
//  channel  | handshake              | payload
//  request  | req_valid / req_stall  | req_type, key_slot, key_time, key_x/y/z, sample_time
//  result   | res_valid / res_stall  | segment, blend, out_x, out_y, out_z
//  config   | cfg_write              | cfg_data (key_count)
//
// A load item is written into its key cell. A sample item walks the row of MAX_KEYS cells;
// when a division is needed it then passes the divider, then the multiplier works through
// the three axes and the output register takes the result; the next request is taken after that.
// Reset clears the control state and sets key_count to one; the stored keys have no reset.
// Requests are stalled while a sample is at work, and a finished sample waits in its last
// step while the previous result is still stalled.
module keyframe_vector_interpolator_core import kvi_pkg::*; #(
	parameter int MAX_KEYS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [KC_W-1:0]     cfg_data,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic                req_type,
	input  logic [SLOT_W-1:0]   key_slot,
	input  logic [VAL_W-1:0]    key_time,
	input  logic signed [VAL_W-1:0] key_x,
	input  logic signed [VAL_W-1:0] key_y,
	input  logic signed [VAL_W-1:0] key_z,
	input  logic [VAL_W-1:0]    sample_time,
	output logic                res_valid,
	input  logic                res_stall,
	output logic [SEG_W-1:0]    segment,
	output logic [BLEND_W-1:0]  blend,
	output logic signed [VAL_W-1:0] out_x,
	output logic signed [VAL_W-1:0] out_y,
	output logic signed [VAL_W-1:0] out_z
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SWEEP = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]         state_q;
	logic [KC_W-1:0]    n_q;
	logic               accept;
	load_t              load;
	pkt_t               head;
	pkt_t               pkt [MAX_KEYS+1];
	pkt_t               last;

	logic [SEG_W-1:0]   seg_q;
	logic [BLEND_W-1:0] blend_q;
	logic [VAL_W-1:0]   st_q [3];
	logic [VAL_W-1:0]   en_q [3];
	logic [VAL_W-1:0]   w_q  [3];
	logic [1:0]         ax_q;
	logic               ph_q;
	logic signed [50:0] prod_q;
	logic signed [32:0] diff;
	logic               div_start;
	logic               div_done;
	logic [FRAC_W-1:0]  div_quot;

	logic               res_valid_q;
	logic [SEG_W-1:0]   res_seg_q;
	logic [BLEND_W-1:0] res_blend_q;
	logic [VAL_W-1:0]   res_x_q;
	logic [VAL_W-1:0]   res_y_q;
	logic [VAL_W-1:0]   res_z_q;
	logic               out_free;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !res_valid_q || !res_stall;

	assign load = '{
		we:   accept && (req_type == REQ_LOAD),
		slot: key_slot,
		key:  '{time_v: key_time, x: key_x, y: key_y, z: key_z}
	};

	always_comb begin
		head       = '0;
		head.valid = accept && (req_type == REQ_SAMPLE);
		head.t     = sample_time;
	end

	assign pkt[0] = head;

	for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
		kvi_cell #(.IDX(i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.load    (load),
			.n       (n_q),
			.pkt_in  (pkt[i]),
			.pkt_out (pkt[i+1])
		);
	end

	assign last = pkt[MAX_KEYS];

	assign div_start = (state_q == ST_SWEEP) && last.valid && (n_q != KC_W'(1)) &&
		last.found && (last.t > last.pv.time_v);

	kvi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (VAL_W'(last.t - last.pv.time_v)),
		.divisor  (VAL_W'(last.en.time_v - last.pv.time_v)),
		.done     (div_done),
		.quot     (div_quot)
	);

	assign diff = $signed({en_q[ax_q][VAL_W-1], en_q[ax_q]}) -
		$signed({st_q[ax_q][VAL_W-1], st_q[ax_q]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= KC_W'(1);
			res_valid_q <= 1'b0;
			ax_q        <= '0;
			ph_q        <= 1'b0;
		end else begin
			if (cfg_write) begin
				if (cfg_data == '0) begin
					n_q <= KC_W'(1);
				end else if ({{(32-KC_W){1'b0}}, cfg_data} > 32'(MAX_KEYS)) begin
					n_q <= KC_W'(MAX_KEYS);
				end else begin
					n_q <= cfg_data;
				end
			end
			if (state_q == ST_DONE && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (req_type == REQ_SAMPLE)) begin
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (last.valid) begin
						ax_q    <= '0;
						ph_q    <= 1'b0;
						state_q <= div_start ? ST_DIV : ST_MUL;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						ax_q <= ax_q + 2'd1;
						if (ax_q == 2'd2) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SWEEP && last.valid) begin
			seg_q    <= last.seg;
			st_q[0]  <= last.pv.x;
			st_q[1]  <= last.pv.y;
			st_q[2]  <= last.pv.z;
			en_q[0]  <= last.en.x;
			en_q[1]  <= last.en.y;
			en_q[2]  <= last.en.z;
			if (n_q == KC_W'(1)) begin
				blend_q <= BLEND_ZERO;
			end else if (!last.found) begin
				blend_q <= BLEND_ONE;
			end else begin
				blend_q <= BLEND_ZERO;
			end
		end
		if (state_q == ST_DIV && div_done) begin
			blend_q <= {1'b0, div_quot};
		end
		if (state_q == ST_MUL) begin
			if (!ph_q) begin
				prod_q <= $signed({1'b0, blend_q}) * diff;
			end else begin
				w_q[ax_q] <= VAL_W'(st_q[ax_q] + VAL_W'(prod_q[47:16]));
			end
		end
		if (state_q == ST_DONE && out_free) begin
			res_seg_q   <= seg_q;
			res_blend_q <= blend_q;
			res_x_q     <= w_q[0];
			res_y_q     <= w_q[1];
			res_z_q     <= w_q[2];
		end
	end

	assign res_valid = res_valid_q;
	assign segment   = res_seg_q;
	assign blend     = res_blend_q;
	assign out_x     = res_x_q;
	assign out_y     = res_y_q;
	assign out_z     = res_z_q;

endmodule

// File: rtl/core/kvi_cell.sv
// One keyframe cell: holds a key and moves the search packet on by one place.
module kvi_cell import kvi_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  load_t           load,
	input  logic [KC_W-1:0] n,
	input  pkt_t            pkt_in,
	output pkt_t            pkt_out
);

	key_t key_q;
	pkt_t nxt;
	pkt_t pkt_q;

	always_ff @(posedge clk) begin
		if (load.we && ({{(32-SLOT_W){1'b0}}, load.slot} == 32'(IDX))) begin
			key_q <= load.key;
		end
	end

	always_comb begin
		nxt = pkt_in;
		if (pkt_in.valid && !pkt_in.found) begin
			if (IDX == 0) begin
				nxt.pv = key_q;
			end else if (32'(IDX) < {{(32-KC_W){1'b0}}, n}) begin
				if (pkt_in.t < key_q.time_v) begin
					nxt.found = 1'b1;
					nxt.seg   = SEG_W'(IDX - 1);
					nxt.en    = key_q;
				end else begin
					nxt.pv = key_q;
					if (IDX == 1) begin
						nxt.en = key_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_q <= '0;
		end else begin
			pkt_q <= nxt;
		end
	end

	assign pkt_out = pkt_q;

endmodule

// File: rtl/core/kvi_div.sv
// Restoring divider giving a sixteen-bit fraction, one quotient bit a cycle.
module kvi_div import kvi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [VAL_W-1:0]  dividend,
	input  logic [VAL_W-1:0]  divisor,
	output logic              done,
	output logic [FRAC_W-1:0] quot
);

	logic              busy_q;
	logic [4:0]        cnt_q;
	logic [VAL_W-1:0]  rem_q;
	logic [VAL_W-1:0]  den_q;
	logic [FRAC_W-1:0] quot_q;
	logic              done_q;
	logic [VAL_W:0]    r2;
	logic              ge;

	assign r2 = {rem_q, 1'b0};
	assign ge = r2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(FRAC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q  <= ge ? VAL_W'(r2 - {1'b0, den_q}) : r2[VAL_W-1:0];
			quot_q <= {quot_q[FRAC_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
